[rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers for the RTL files.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising clock edge, masked while reset is high.
`define ASSERT_IMPL(label, clk, rst, cond, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error(msg);

// Next-cycle implication, masked while reset is high.
`define ASSERT_NEXT(label, clk, rst, cond, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error(msg);

`endif

[rtl/sccb_pkg.sv]
// ----------------------------------------------------------------------------
// sccb_pkg
// Phase codes, byte slots and bus constants of the SCCB register master.
// ----------------------------------------------------------------------------
package sccb_pkg;

   // Bus sequencer phases, one-hot.
   typedef enum logic [19:0] {
      PH_IDLE = 20'h00001,
      PH_SA   = 20'h00002,
      PH_SB   = 20'h00004,
      PH_WLO  = 20'h00008,
      PH_WHI  = 20'h00010,
      PH_ALO  = 20'h00020,
      PH_AHI  = 20'h00040,
      PH_G1   = 20'h00080,
      PH_G2   = 20'h00100,
      PH_PA   = 20'h00200,
      PH_PB   = 20'h00400,
      PH_PC   = 20'h00800,
      PH_G3   = 20'h01000,
      PH_G4   = 20'h02000,
      PH_RLO  = 20'h04000,
      PH_RHI  = 20'h08000,
      PH_NA   = 20'h10000,
      PH_NB   = 20'h20000,
      PH_NC   = 20'h40000,
      PH_ND   = 20'h80000
   } phase_type;

   // Byte slot within a transaction.
   typedef logic [1:0] byte_idx_type;
   localparam byte_idx_type BYTE_DEV   = 2'd0;
   localparam byte_idx_type BYTE_REG   = 2'd1;
   localparam byte_idx_type BYTE_RDEV  = 2'd2;
   localparam byte_idx_type BYTE_RDATA = 2'd3;

   // Operation codes.
   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_READ  = 1'b1;

   // Register indexes of the configuration port.
   localparam logic CSR_DEVICE_ADDRESS    = 1'b0;
   localparam logic CSR_HALF_PERIOD_TICKS = 1'b1;

   localparam logic [7:0]  DEVICE_ADDRESS_RESET = 8'h42;
   localparam logic [15:0] HALF_PERIOD_RESET    = 16'd50;
   localparam logic [7:0]  READ_FLAG            = 8'h01;
   localparam logic [3:0]  BITS_PER_BYTE        = 4'd8;

endpackage

[rtl/sccb_register_master.sv]
// Registered: an accepted tick item's result item is offered in the next cycle.
// Throughput: one tick item per clock cycle; the result register frees as it is
//   taken, so req_tready only drops while a result waits with rsp_tready low.
// Reset (synchronous, active high): sequencer idle, SCL and SDA high, counters
//   and flags cleared, device_address 0x42, half_period_ticks 50.
// ----------------------------------------------------------------------------
// sccb_register_master
// SCCB two-wire camera bus master: one tick item in, one pin/status item
// out. A half-period tick counter paces a one-hot phase sequencer that sends
// register writes and register reads.
// ----------------------------------------------------------------------------
module sccb_register_master (
   input  logic        clock,
   input  logic        reset,
   // tick items
   input  logic        req_tvalid,
   output logic        req_tready,
   // [0] start_request, [8:1] reg_addr, [16:9] write_data, [17] sda_in, rest 0
   input  logic [23:0] req_tdata,
   // [0] operation
   input  logic [0:0]  req_tuser,
   // result items
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [0] scl_level, [1] sda_level, [2] sda_release, [3] busy_res,
   // [4] done_res, [5] nack_seen, [13:6] read_data, rest 0
   output logic [15:0] rsp_tdata,
   // configuration writes
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [15:0] csr_data
);
   import sccb_pkg::*;
`include "assert_macros.svh"

   // Configuration registers
   logic [7:0]  dev_addr_ff;
   logic [15:0] half_ff;

   // Sequencer state
   phase_type    phase_ff,  phase_in;
   logic [3:0]   bit_ff,    bit_in;
   logic [7:0]   shift_ff,  shift_in;
   logic [15:0]  tick_ff,   tick_in;
   logic         hop_ff,    hop_in;
   logic [7:0]   hreg_ff,   hreg_in;
   logic [7:0]   hdata_ff,  hdata_in;
   logic         nack_ff,   nack_in;
   logic         scl_ff,    scl_in;
   logic         sda_ff,    sda_in_nx;
   byte_idx_type bidx_ff,   bidx_in;
   logic         rel_ff,    rel_in;

   // Result register
   logic        out_valid_ff, out_valid_in;
   logic [15:0] out_data_ff,  out_data_in;

   // Unpacked input fields
   logic       f_start, f_op, f_sda;
   logic [7:0] f_reg, f_data;

   logic        accept;
   logic        done;
   logic [15:0] tick_inc;
   logic [15:0] limit;
   logic        step;

   assign f_start = req_tdata[0];
   assign f_reg   = req_tdata[8:1];
   assign f_data  = req_tdata[16:9];
   assign f_sda   = req_tdata[17];
   assign f_op    = req_tuser[0];

   // Take a new tick whenever the result register is empty or being drained.
   assign req_tready = !out_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   // A zero half period still takes one tick per step; the step also ends at once
   // when the period shrinks below the running count, and on a counter wrap.
   assign tick_inc = tick_ff + 16'd1;
   assign limit    = (half_ff == 16'd0) ? 16'd1 : half_ff;
   assign step     = (tick_inc >= limit) || (tick_inc == 16'd0);

   always_comb begin
      phase_in  = phase_ff;
      bit_in    = bit_ff;
      shift_in  = shift_ff;
      tick_in   = tick_ff;
      hop_in    = hop_ff;
      hreg_in   = hreg_ff;
      hdata_in  = hdata_ff;
      nack_in   = nack_ff;
      scl_in    = scl_ff;
      sda_in_nx = sda_ff;
      bidx_in   = bidx_ff;
      rel_in    = rel_ff;
      done      = 1'b0;

      if (phase_ff == PH_IDLE) begin
         // Latch the request; the first delay step starts on the next tick.
         if (f_start) begin
            hop_in    = f_op;
            hreg_in   = f_reg;
            hdata_in  = f_data;
            nack_in   = 1'b0;
            shift_in  = 8'd0;
            bit_in    = 4'd0;
            bidx_in   = BYTE_DEV;
            tick_in   = 16'd0;
            rel_in    = 1'b0;
            scl_in    = 1'b1;
            sda_in_nx = 1'b1;
            phase_in  = PH_SA;
         end
      end else begin
         tick_in = tick_inc;
         if (step) begin
            tick_in = 16'd0;
            case (phase_ff)
               PH_SA: begin
                  sda_in_nx = 1'b0;
                  phase_in  = PH_SB;
               end
               PH_SB: begin
                  // Load the address byte; a restart uses the read form.
                  scl_in    = 1'b0;
                  shift_in  = (bidx_ff == BYTE_RDEV) ? (dev_addr_ff | READ_FLAG)
                                                     : dev_addr_ff;
                  bit_in    = 4'd0;
                  rel_in    = 1'b0;
                  sda_in_nx = shift_in[7];
                  phase_in  = PH_WLO;
               end
               PH_WLO: begin
                  scl_in   = 1'b1;
                  phase_in = PH_WHI;
               end
               PH_WHI: begin
                  scl_in   = 1'b0;
                  shift_in = {shift_ff[6:0], 1'b0};
                  bit_in   = bit_ff + 4'd1;
                  if (bit_in < BITS_PER_BYTE) begin
                     sda_in_nx = shift_in[7];
                     phase_in  = PH_WLO;
                  end else begin
                     rel_in   = 1'b1;
                     phase_in = PH_ALO;
                  end
               end
               PH_ALO: begin
                  scl_in   = 1'b1;
                  phase_in = PH_AHI;
               end
               PH_AHI: begin
                  // Sample the acknowledge; only writes record a NACK.
                  if (hop_ff == OP_WRITE && f_sda) begin
                     nack_in = 1'b1;
                  end
                  scl_in = 1'b0;
                  rel_in = 1'b0;
                  if (hop_ff == OP_WRITE && bidx_ff == BYTE_RDEV) begin
                     sda_in_nx = 1'b0;
                     phase_in  = PH_PA;
                  end else begin
                     phase_in = PH_G1;
                  end
               end
               PH_G1: begin
                  phase_in = PH_G2;
               end
               PH_G2: begin
                  if (hop_ff == OP_WRITE) begin
                     bidx_in   = bidx_ff + 2'd1;
                     shift_in  = (bidx_in == BYTE_REG) ? hreg_ff : hdata_ff;
                     bit_in    = 4'd0;
                     rel_in    = 1'b0;
                     sda_in_nx = shift_in[7];
                     phase_in  = PH_WLO;
                  end else if (bidx_ff == BYTE_DEV) begin
                     bidx_in   = BYTE_REG;
                     shift_in  = hreg_ff;
                     bit_in    = 4'd0;
                     rel_in    = 1'b0;
                     sda_in_nx = hreg_ff[7];
                     phase_in  = PH_WLO;
                  end else if (bidx_ff == BYTE_REG) begin
                     rel_in    = 1'b0;
                     sda_in_nx = 1'b0;
                     phase_in  = PH_PA;
                  end else begin
                     bidx_in  = BYTE_RDATA;
                     shift_in = 8'd0;
                     bit_in   = 4'd0;
                     rel_in   = 1'b1;
                     phase_in = PH_RLO;
                  end
               end
               PH_PA: begin
                  scl_in   = 1'b1;
                  phase_in = PH_PB;
               end
               PH_PB: begin
                  sda_in_nx = 1'b1;
                  phase_in  = PH_PC;
               end
               PH_PC: begin
                  // The stop after the register byte of a read leads to a restart.
                  if (hop_ff == OP_READ && bidx_ff == BYTE_REG) begin
                     phase_in = PH_G3;
                  end else begin
                     phase_in = PH_IDLE;
                     done     = 1'b1;
                  end
               end
               PH_G3: begin
                  phase_in = PH_G4;
               end
               PH_G4: begin
                  sda_in_nx = 1'b1;
                  scl_in    = 1'b1;
                  bidx_in   = BYTE_RDEV;
                  phase_in  = PH_SA;
               end
               PH_RLO: begin
                  scl_in   = 1'b1;
                  shift_in = {shift_ff[6:0], f_sda};
                  phase_in = PH_RHI;
               end
               PH_RHI: begin
                  scl_in = 1'b0;
                  bit_in = bit_ff + 4'd1;
                  if (bit_in < BITS_PER_BYTE) begin
                     phase_in = PH_RLO;
                  end else begin
                     rel_in   = 1'b0;
                     phase_in = PH_NA;
                  end
               end
               PH_NA: begin
                  sda_in_nx = 1'b1;
                  scl_in    = 1'b1;
                  phase_in  = PH_NB;
               end
               PH_NB: begin
                  scl_in   = 1'b0;
                  phase_in = PH_NC;
               end
               PH_NC: begin
                  sda_in_nx = 1'b0;
                  phase_in  = PH_ND;
               end
               PH_ND: begin
                  rel_in    = 1'b0;
                  sda_in_nx = 1'b0;
                  phase_in  = PH_PA;
               end
               default: begin
                  phase_in = PH_IDLE;
               end
            endcase
         end
      end
   end

   // Pack the result item from the post-tick state.
   always_comb begin
      out_data_in        = 16'd0;
      out_data_in[0]     = scl_in;
      out_data_in[1]     = sda_in_nx;
      out_data_in[2]     = rel_in;
      out_data_in[3]     = (phase_in != PH_IDLE);
      out_data_in[4]     = done;
      out_data_in[5]     = done && nack_in;
      out_data_in[13:6]  = (done && hop_ff == OP_READ) ? shift_in : 8'd0;
   end

   // Hold the result until taken; load a fresh one with every accepted tick.
   always_comb begin
      out_valid_in = out_valid_ff;
      if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
      if (accept) begin
         out_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dev_addr_ff  <= DEVICE_ADDRESS_RESET;
         half_ff      <= HALF_PERIOD_RESET;
         phase_ff     <= PH_IDLE;
         bit_ff       <= 4'd0;
         shift_ff     <= 8'd0;
         tick_ff      <= 16'd0;
         hop_ff       <= 1'b0;
         hreg_ff      <= 8'd0;
         hdata_ff     <= 8'd0;
         nack_ff      <= 1'b0;
         scl_ff       <= 1'b1;
         sda_ff       <= 1'b1;
         bidx_ff      <= BYTE_DEV;
         rel_ff       <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_DEVICE_ADDRESS:    dev_addr_ff <= csr_data[7:0];
               CSR_HALF_PERIOD_TICKS: half_ff     <= csr_data;
               default:               half_ff     <= half_ff;
            endcase
         end
         // Advance the sequencer only on accepted ticks.
         if (accept) begin
            phase_ff <= phase_in;
            bit_ff   <= bit_in;
            shift_ff <= shift_in;
            tick_ff  <= tick_in;
            hop_ff   <= hop_in;
            hreg_ff  <= hreg_in;
            hdata_ff <= hdata_in;
            nack_ff  <= nack_in;
            scl_ff   <= scl_in;
            sda_ff   <= sda_in_nx;
            bidx_ff  <= bidx_in;
            rel_ff   <= rel_in;
         end
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         out_data_ff <= out_data_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

   // SDA is released only around the acknowledge slot and the read bits.
   `ASSERT_IMPL(a_release_phase, clock, reset, rel_ff,
      (phase_ff == PH_ALO || phase_ff == PH_AHI || phase_ff == PH_RLO ||
       phase_ff == PH_RHI), "SDA released outside acknowledge or read bits")

   // An accepted start while idle enters the start condition.
   `ASSERT_NEXT(a_start_enters, clock, reset,
      accept && phase_ff == PH_IDLE && f_start, phase_ff == PH_SA,
      "start request did not begin a transaction")

   // The bit counter never runs past one byte.
   `ASSERT_IMPL(a_bit_range, clock, reset, phase_ff != PH_IDLE,
      bit_ff <= BITS_PER_BYTE, "bit counter out of range")

   // A finishing result reports the block as no longer busy.
   `ASSERT_IMPL(a_done_not_busy, clock, reset, rsp_tvalid && rsp_tdata[4],
      !rsp_tdata[3], "done reported while still busy")

endmodule
